// ===== rtl/ptq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared codes and types for the priority thread queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int ID_BITS   = 4;
  localparam int KIND_BITS = 3;
  localparam int STAT_BITS = 2;

  localparam logic [KIND_BITS-1:0] KIND_INS_PRIO = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_INS_TAIL = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_RM_HEAD  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_RM_TAIL  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_RM_ID    = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd3;

  // Decoded operation, broadcast to every cell.
  typedef struct packed {
    logic ins_prio;
    logic ins_tail;
    logic rm_head;
    logic rm_tail;
    logic rm_id;
  } op_t;

endpackage

// ===== rtl/ptq_cell.sv =====
// ----------------------------------------------------------------------------
// ptq_cell
// One queue slot: holds an entry, finds the operation's position from the
// chain, and shifts from its left or right neighbor on commit.
// ----------------------------------------------------------------------------
module ptq_cell #(
  parameter int PRIO_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        commit,
  input  ptq_pkg::op_t                op,
  input  logic [ptq_pkg::ID_BITS-1:0] req_id,
  input  logic [PRIO_BITS-1:0]        req_prio,
  input  logic                        left_valid,
  input  logic [ptq_pkg::ID_BITS-1:0] left_id,
  input  logic [PRIO_BITS-1:0]        left_prio,
  input  logic                        right_valid,
  input  logic [ptq_pkg::ID_BITS-1:0] right_id,
  input  logic [PRIO_BITS-1:0]        right_prio,
  input  logic                        found_in,
  input  logic [ptq_pkg::ID_BITS-1:0] sel_id_in,
  input  logic [PRIO_BITS-1:0]        sel_prio_in,
  output logic                        valid,
  output logic [ptq_pkg::ID_BITS-1:0] id,
  output logic [PRIO_BITS-1:0]        prio,
  output logic                        found_out,
  output logic [ptq_pkg::ID_BITS-1:0] sel_id_out,
  output logic [PRIO_BITS-1:0]        sel_prio_out
);

  logic                        stop;
  logic                        here;
  logic                        valid_next;
  logic [ptq_pkg::ID_BITS-1:0] id_next;
  logic [PRIO_BITS-1:0]        prio_next;

  always_comb begin
    stop = 1'b0;
    if (op.ins_prio) begin
      stop = !(valid && (prio >= req_prio));
    end else if (op.ins_tail) begin
      stop = !valid;
    end else if (op.rm_head) begin
      stop = valid;
    end else if (op.rm_tail) begin
      stop = valid && !right_valid;
    end else if (op.rm_id) begin
      stop = valid && (id == req_id);
    end
  end

  assign here         = stop && !found_in;
  assign found_out    = found_in || stop;
  assign sel_id_out   = here ? id   : sel_id_in;
  assign sel_prio_out = here ? prio : sel_prio_in;

  always_comb begin
    valid_next = valid;
    id_next    = id;
    prio_next  = prio;
    if (op.ins_prio || op.ins_tail) begin
      if (here) begin
        valid_next = 1'b1;
        id_next    = req_id;
        prio_next  = req_prio;
      end else if (found_in) begin
        valid_next = left_valid;
        id_next    = left_id;
        prio_next  = left_prio;
      end
    end else if (here || found_in) begin
      valid_next = right_valid;
      id_next    = right_id;
      prio_next  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (commit) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      id   <= id_next;
      prio <= prio_next;
    end
  end

endmodule

// ===== rtl/priority_thread_queue.sv =====
// ----------------------------------------------------------------------------
// priority_thread_queue
// Priority-ordered ready queue of thread ids built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Takes one transaction per clock and returns its result in the output
// register in the following cycle. A new transaction is accepted only while
// that register is empty or being taken in the same cycle, so a stalled
// result holds off intake. Every cell compares against the request in
// parallel and the chain resolves the first matching position and shifts
// all slots in the same cycle, so the combinational depth grows with
// MAX_ENTRIES along that chain. Slots are kept contiguous from the head.
// Insert into a full queue, removal from an empty queue and removal of an
// absent id leave the queue unchanged and report a status code.
module priority_thread_queue #(
  parameter int MAX_ENTRIES = 16,
  parameter int PRIO_BITS   = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [3:0] thread_id, [PRIO_BITS+3:4] priority_req, zero pad to bytes
  input  logic [((ptq_pkg::ID_BITS+PRIO_BITS+7)/8)*8-1:0] s_tdata,
  // [2:0] kind
  input  logic [ptq_pkg::KIND_BITS-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // [3:0] removed_id, [PRIO_BITS+3:4] removed_priority, then occupancy,
  // zero pad to bytes
  output logic [((ptq_pkg::ID_BITS+PRIO_BITS+$clog2(MAX_ENTRIES+1)+7)/8)*8-1:0] m_tdata,
  // [1:0] status
  output logic [ptq_pkg::STAT_BITS-1:0] m_tuser
);

  localparam int CW     = $clog2(MAX_ENTRIES + 1);
  localparam int IB     = ptq_pkg::ID_BITS;
  localparam int OUT_W  = IB + PRIO_BITS + CW;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  logic                 accept;
  logic [2:0]           kind;
  logic [IB-1:0]        req_id;
  logic [PRIO_BITS-1:0] req_prio;
  ptq_pkg::op_t         op;
  logic                 is_ins;
  logic                 is_rm;
  logic                 full;
  logic                 empty;
  logic                 found;
  logic                 commit;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [ptq_pkg::STAT_BITS-1:0] status;
  logic [IB-1:0]        rid;
  logic [PRIO_BITS-1:0] rprio;

  logic [MAX_ENTRIES-1:0]  valid_w;
  logic [IB-1:0]           id_w   [MAX_ENTRIES];
  logic [PRIO_BITS-1:0]    prio_w [MAX_ENTRIES];
  logic [MAX_ENTRIES:0]    found_w;
  logic [IB-1:0]           sel_id_w   [MAX_ENTRIES+1];
  logic [PRIO_BITS-1:0]    sel_prio_w [MAX_ENTRIES+1];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign kind     = s_tuser;
  assign req_id   = s_tdata[IB-1:0];
  assign req_prio = s_tdata[IB+PRIO_BITS-1:IB];

  assign op.ins_prio = (kind == ptq_pkg::KIND_INS_PRIO);
  assign op.ins_tail = (kind == ptq_pkg::KIND_INS_TAIL);
  assign op.rm_head  = (kind == ptq_pkg::KIND_RM_HEAD);
  assign op.rm_tail  = (kind == ptq_pkg::KIND_RM_TAIL);
  assign op.rm_id    = (kind == ptq_pkg::KIND_RM_ID);

  assign is_ins = op.ins_prio || op.ins_tail;
  assign is_rm  = op.rm_head || op.rm_tail || op.rm_id;
  assign full   = valid_w[MAX_ENTRIES-1];
  assign empty  = !valid_w[0];
  assign found  = found_w[MAX_ENTRIES];

  assign found_w[0]    = 1'b0;
  assign sel_id_w[0]   = '0;
  assign sel_prio_w[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                 lv;
    logic [IB-1:0]        lid;
    logic [PRIO_BITS-1:0] lpr;
    logic                 rv;
    logic [IB-1:0]        rdid;
    logic [PRIO_BITS-1:0] rpr;

    if (i == 0) begin : g_head
      assign lv  = 1'b0;
      assign lid = '0;
      assign lpr = '0;
    end else begin : g_mid_l
      assign lv  = valid_w[i-1];
      assign lid = id_w[i-1];
      assign lpr = prio_w[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign rv   = 1'b0;
      assign rdid = '0;
      assign rpr  = '0;
    end else begin : g_mid_r
      assign rv   = valid_w[i+1];
      assign rdid = id_w[i+1];
      assign rpr  = prio_w[i+1];
    end

    ptq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .commit      (commit),
      .op          (op),
      .req_id      (req_id),
      .req_prio    (req_prio),
      .left_valid  (lv),
      .left_id     (lid),
      .left_prio   (lpr),
      .right_valid (rv),
      .right_id    (rdid),
      .right_prio  (rpr),
      .found_in    (found_w[i]),
      .sel_id_in   (sel_id_w[i]),
      .sel_prio_in (sel_prio_w[i]),
      .valid       (valid_w[i]),
      .id          (id_w[i]),
      .prio        (prio_w[i]),
      .found_out   (found_w[i+1]),
      .sel_id_out  (sel_id_w[i+1]),
      .sel_prio_out(sel_prio_w[i+1])
    );
  end

  always_comb begin
    status     = ptq_pkg::ST_OK;
    rid        = '0;
    rprio      = '0;
    commit     = 1'b0;
    count_next = count;
    if (is_ins) begin
      if (full) begin
        status = ptq_pkg::ST_FULL;
      end else begin
        commit     = accept;
        count_next = count + CW'(1);
      end
    end else if (is_rm) begin
      if (empty) begin
        status = ptq_pkg::ST_EMPTY;
      end else if (!found) begin
        status = ptq_pkg::ST_NOT_FOUND;
      end else begin
        commit     = accept;
        rid        = sel_id_w[MAX_ENTRIES];
        rprio      = sel_prio_w[MAX_ENTRIES];
        count_next = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_TW'({count_next, rprio, rid});
      m_tuser <= status;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(valid_w)))
    else $error("occupancy count disagrees with occupied slots");

  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_w & (valid_w + MAX_ENTRIES'(1))) == '0)
    else $error("occupied slots are not contiguous from the head");

  a_full_insert_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && is_ins && full) |=> (count == $past(count)))
    else $error("insert into full queue changed occupancy");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted transaction produced no result");

endmodule
